// ===== hdl/deq_pkg.sv =====
package deq_pkg;

    // Default geometry and fixed port widths
    localparam int DEQ_DEPTH  = 16;
    localparam int DEQ_WIDTH  = 64;
    localparam int DATA_W     = 64;
    localparam int FUNC_W     = 3;
    localparam int COUNT_W    = 5;
    localparam int ERR_W      = 2;

    // Request selector codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_QUERY      = 3'd4
    } deq_func_t;

    // Result error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } deq_err_t;

    // What every cell of a row does when the row is clocked
    typedef enum logic [1:0] {
        RM_HOLD      = 2'd0,
        RM_SHIFT_IN  = 2'd1,
        RM_SHIFT_OUT = 2'd2,
        RM_WRITE_AT  = 2'd3
    } row_mode_t;

    // Request word
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] value;
    } deq_in_t;

    // Result word
    typedef struct packed {
        logic [DATA_W-1:0]  front_value;
        logic [DATA_W-1:0]  back_value;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        logic [ERR_W-1:0]   error;
    } deq_out_t;

endpackage

// ===== hdl/deq_cell.sv =====
module deq_cell
    import deq_pkg::*;
#(
    parameter int WIDTH = DEQ_WIDTH,
    parameter int CW    = $clog2(DEQ_DEPTH + 1),
    parameter int INDEX = 0
) (
    input  logic             aclk,
    input  row_mode_t        mode,
    input  logic [CW-1:0]    wr_pos,
    input  logic [WIDTH-1:0] value,
    input  logic [WIDTH-1:0] left_data,
    input  logic [WIDTH-1:0] right_data,
    output logic [WIDTH-1:0] data_q,
    output logic [WIDTH-1:0] data_d
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;
    logic             wr_hit;

    assign wr_hit = (wr_pos == CW'(INDEX));

    // Pick the next entry from the neighbors or the incoming word
    always_comb begin
        case (mode)
            RM_SHIFT_IN:  data_next = left_data;
            RM_SHIFT_OUT: data_next = right_data;
            RM_WRITE_AT:  data_next = wr_hit ? value : data_reg;
            default:      data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;
    assign data_d = data_next;

endmodule

// ===== hdl/deq_row.sv =====
module deq_row
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH,
    parameter int WIDTH = DEQ_WIDTH,
    parameter int CW    = $clog2(DEQ_DEPTH + 1)
) (
    input  logic             aclk,
    input  row_mode_t        mode,
    input  logic [CW-1:0]    wr_pos,
    input  logic [WIDTH-1:0] value,
    output logic [WIDTH-1:0] head_next
);

    logic [WIDTH-1:0] cell_q [DEPTH];
    logic [WIDTH-1:0] cell_d [DEPTH];

    // Line up the cells; the new word enters at cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WIDTH-1:0] left_w;
        logic [WIDTH-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = value;
        end else begin : g_mid_l
            assign left_w = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = cell_q[i];
        end else begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        deq_cell #(
            .WIDTH (WIDTH),
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .mode       (mode),
            .wr_pos     (wr_pos),
            .value      (value),
            .left_data  (left_w),
            .right_data (right_w),
            .data_q     (cell_q[i]),
            .data_d     (cell_d[i])
        );
    end

    assign head_next = cell_d[0];

endmodule

// ===== hdl/double_ended_queue.sv =====
// Bounded double-ended queue of WIDTH-bit words, DEPTH entries.
// Input channel s_valid/s_ready/s_data carries one request word: push back,
// push front, pop front, pop back or query (unused selector codes query).
// Output channel m_valid/m_ready/m_data returns exactly one result word per
// request: front and back entries after the request (zero when empty), the
// entry count, an empty flag and an error code (pop on empty, push on full;
// the queue is then left unchanged).
// Storage is two rows of cells: one keeps the queue lined up from the front
// at cell 0, the other lined up from the back at cell 0, so every push or pop
// shifts a row by one cell, and a push also writes the cell at the current count.
// The result is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while the receiver takes each result, set by the single output register.
// When the receiver stalls, the result holds in the output register and
// s_ready drops until it is taken; no request is lost or repeated.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; no clearing pass is needed, the cells hold no reset value.
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH,
    parameter int WIDTH = DEQ_WIDTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  deq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output deq_out_t m_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    deq_out_t         m_data_reg;
    deq_out_t         m_data_next;
    logic             accept;
    logic             full;
    logic             empty;
    row_mode_t        front_mode;
    row_mode_t        back_mode;
    deq_err_t         err;
    logic [WIDTH-1:0] push_word;
    logic [WIDTH-1:0] front_head;
    logic [WIDTH-1:0] back_head;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign push_word = s_data.value[WIDTH-1:0];

    // Decode the request into row moves and the new count
    always_comb begin
        front_mode = RM_HOLD;
        back_mode  = RM_HOLD;
        err        = ERR_OK;
        count_next = count_reg;
        case (deq_func_t'(s_data.func))
            FN_PUSH_BACK: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    front_mode = RM_WRITE_AT;
                    back_mode  = RM_SHIFT_IN;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_PUSH_FRONT: begin
                if (full) begin
                    err = ERR_FULL;
                end else begin
                    front_mode = RM_SHIFT_IN;
                    back_mode  = RM_WRITE_AT;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_POP_FRONT: begin
                if (empty) begin
                    err = ERR_EMPTY;
                end else begin
                    front_mode = RM_SHIFT_OUT;
                    count_next = count_reg - 1'b1;
                end
            end
            FN_POP_BACK: begin
                if (empty) begin
                    err = ERR_EMPTY;
                end else begin
                    back_mode  = RM_SHIFT_OUT;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
        // Hold both rows unless a request is taken
        if (!accept) begin
            front_mode = RM_HOLD;
            back_mode  = RM_HOLD;
            count_next = count_reg;
        end
    end

    deq_row #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .CW    (CW)
    ) u_front_row (
        .aclk      (aclk),
        .mode      (front_mode),
        .wr_pos    (count_reg),
        .value     (push_word),
        .head_next (front_head)
    );

    deq_row #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .CW    (CW)
    ) u_back_row (
        .aclk      (aclk),
        .mode      (back_mode),
        .wr_pos    (count_reg),
        .value     (push_word),
        .head_next (back_head)
    );

    // Build the result word from the updated rows
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next          = 1'b1;
            m_data_next.count     = COUNT_W'(count_next);
            m_data_next.empty_res = (count_next == '0);
            m_data_next.error     = err;
            if (count_next == '0) begin
                m_data_next.front_value = '0;
                m_data_next.back_value  = '0;
            end else begin
                m_data_next.front_value = DATA_W'(front_head);
                m_data_next.back_value  = DATA_W'(back_head);
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.empty_res |->
            (m_data.front_value == '0) && (m_data.back_value == '0))
        else $error("empty result carries nonzero entries");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !empty && (s_data.func == FN_POP_FRONT || s_data.func == FN_POP_BACK)
        |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not drop the count");
`endif

endmodule

// ===== tb/tb_double_ended_queue.sv =====
module tb_double_ended_queue;
    import deq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_OFF     = 80;
    localparam int DRAIN_CYCLES = 4;
    localparam int FUNC_CODES   = 1 << FUNC_W;
    localparam int SPARE_FIRST  = int'(FN_QUERY) + 1;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    deq_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    deq_out_t m_data;

    // Predicted deque contents
    logic [DATA_W-1:0] ring [DEQ_DEPTH];
    int                ring_head;
    int                ring_fill;

    // Predicted result words, oldest first
    deq_out_t deque_snapshots [$];

    int mismatch_count;
    int quiet_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;

    double_ended_queue u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        $display("%0t: %s: got %h, want %h", $time, what, got, want);
    endtask

    // Apply one request to the predicted deque and queue the result word
    task automatic apply_request(input deq_in_t req);
        deq_out_t res;
        deq_err_t err;
        err = ERR_OK;
        case (deq_func_t'(req.func))
            FN_PUSH_BACK: begin
                if (ring_fill == DEQ_DEPTH) begin
                    err = ERR_FULL;
                end else begin
                    ring[(ring_head + ring_fill) % DEQ_DEPTH] = req.value;
                    ring_fill++;
                end
            end
            FN_PUSH_FRONT: begin
                if (ring_fill == DEQ_DEPTH) begin
                    err = ERR_FULL;
                end else begin
                    ring_head = (ring_head + DEQ_DEPTH - 1) % DEQ_DEPTH;
                    ring[ring_head] = req.value;
                    ring_fill++;
                end
            end
            FN_POP_FRONT: begin
                if (ring_fill == 0) begin
                    err = ERR_EMPTY;
                end else begin
                    ring_head = (ring_head + 1) % DEQ_DEPTH;
                    ring_fill--;
                end
            end
            FN_POP_BACK: begin
                if (ring_fill == 0) begin
                    err = ERR_EMPTY;
                end else begin
                    ring_fill--;
                end
            end
            // query and unused selectors change nothing
            default: ;
        endcase
        if (ring_fill == 0) begin
            res.front_value = '0;
            res.back_value  = '0;
        end else begin
            res.front_value = ring[ring_head];
            res.back_value  = ring[(ring_head + ring_fill - 1) % DEQ_DEPTH];
        end
        res.count     = COUNT_W'(ring_fill);
        res.empty_res = (ring_fill == 0);
        res.error     = err;
        deque_snapshots.push_back(res);
    endtask

    // Predict on each accepted request, then check each accepted result word
    always @(posedge aclk) begin
        deq_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                apply_request(s_data);
            end
            if (m_valid && m_ready) begin
                if (deque_snapshots.size() == 0) begin
                    report_mismatch("result word with no request outstanding",
                                    m_data.front_value, '0);
                end else begin
                    want = deque_snapshots.pop_front();
                    if (m_data.front_value !== want.front_value)
                        report_mismatch("front_value", m_data.front_value, want.front_value);
                    if (m_data.back_value !== want.back_value)
                        report_mismatch("back_value", m_data.back_value, want.back_value);
                    if (m_data.count !== want.count)
                        report_mismatch("count", DATA_W'(m_data.count),
                                        DATA_W'(want.count));
                    if (m_data.empty_res !== want.empty_res)
                        report_mismatch("empty_res", DATA_W'(m_data.empty_res),
                                        DATA_W'(want.empty_res));
                    if (m_data.error !== want.error)
                        report_mismatch("error", DATA_W'(m_data.error),
                                        DATA_W'(want.error));
                end
            end
            // watchdog: end the run when nothing moves for too long
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // Result side: random stalls, or a counted hold-off when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one request word and wait for it to be taken; valid stays high on return
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data.func  <= func;
        s_data.value <= value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Empty-queue errors, unused selectors, extreme values
    task automatic test_edge_cases();
        send_request(FN_QUERY, '1);
        send_request(FN_POP_FRONT, '1);
        send_request(FN_POP_BACK, '0);
        for (int code = SPARE_FIRST; code < FUNC_CODES; code++) begin
            send_request(FUNC_W'(code), random_word());
        end
        send_request(FN_PUSH_BACK, '1);
        send_request(FN_PUSH_FRONT, '0);
        send_request(FN_PUSH_BACK, {DATA_W/2{2'b10}});
        send_request(FN_PUSH_FRONT, {DATA_W/2{2'b01}});
        send_request(FN_QUERY, '0);
        send_request(FN_POP_BACK, '0);
        send_request(FN_POP_FRONT, '0);
        send_request(FN_POP_BACK, '1);
        send_request(FN_POP_FRONT, '1);
        send_request(FN_POP_FRONT, '0);
        send_request(FN_QUERY, '1);
    endtask

    // Fill to full from both ends, push on full, then drain past empty
    task automatic test_fill_and_drain();
        for (int i = 0; i < DEQ_DEPTH; i++) begin
            send_request(i[0] ? FN_PUSH_FRONT : FN_PUSH_BACK, random_word());
        end
        send_request(FN_PUSH_BACK, random_word());
        send_request(FN_PUSH_FRONT, random_word());
        send_request(FN_QUERY, random_word());
        for (int i = 0; i < DEQ_DEPTH; i++) begin
            send_request(i[1] ? FN_POP_BACK : FN_POP_FRONT, random_word());
        end
        send_request(FN_POP_FRONT, random_word());
        send_request(FN_POP_BACK, random_word());
    endtask

    // Random walk that swings between filling and draining so both limits are hit
    task automatic test_random_walk(input int n_items);
        int push_pct;
        int roll;
        push_pct = 30;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) push_pct = (push_pct == 70) ? 30 : 70;
            roll = $urandom_range(99);
            if (roll < 4) begin
                send_request(FN_QUERY, random_word());
            end else if (roll < 8) begin
                send_request(FUNC_W'($urandom_range(FUNC_CODES - 1, SPARE_FIRST)),
                             random_word());
            end else if ($urandom_range(99) < push_pct) begin
                send_request($urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_BACK,
                             random_word());
            end else begin
                send_request($urandom_range(1) ? FN_POP_FRONT : FN_POP_BACK,
                             random_word());
            end
        end
    endtask

    // Hold off the result side while requests keep coming, so the input stalls
    task automatic test_backpressure();
        hold_off_cycles = HOLD_OFF;
        for (int i = 0; i < 40; i++) begin
            send_request(($urandom_range(3) != 0) ? FN_PUSH_BACK : FN_POP_FRONT,
                         random_word());
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        hold_off_cycles = 0;
        ring_head       = 0;
        ring_fill       = 0;
        send_idle_pct   = 23;
        recv_idle_pct   = 56;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_edge_cases();
        test_fill_and_drain();
        test_random_walk(340);

        send_idle_pct = 56;
        recv_idle_pct = 23;
        test_random_walk(340);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_walk(340);
        test_fill_and_drain();

        // drop valid and let every outstanding result word come back
        s_valid <= 1'b0;
        while (deque_snapshots.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/deq_row.sv
hdl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
